// ===== src/dnd_pkg.sv =====
// Shared types, constants and the month table for the day-number-to-date converter.
package dnd_pkg;

    typedef logic [21:0] day_count_t;
    typedef logic [13:0] year_t;
    typedef logic [3:0]  month_t;
    typedef logic [4:0]  mday_t;
    typedef logic [2:0]  weekday_t;

    localparam day_count_t DAYS_TO_END = 22'd2921940;
    localparam year_t      FIRST_YEAR  = 14'd2000;

    localparam day_count_t LEN_400Y      = 22'd146097;
    localparam day_count_t LEN_100Y_LEAP = 22'd36525;
    localparam day_count_t LEN_100Y      = 22'd36524;
    localparam day_count_t LEN_4Y_LEAP   = 22'd1461;
    localparam day_count_t LEN_4Y        = 22'd1460;
    localparam day_count_t LEN_1Y_LEAP   = 22'd366;
    localparam day_count_t LEN_1Y        = 22'd365;

    localparam month_t LAST_MONTH = 4'd11;

    function automatic mday_t month_days(input month_t mon, input logic leap);
        mday_t d;
        case (mon)
            4'd1:    d = leap ? 5'd29 : 5'd28;
            4'd3,
            4'd5,
            4'd8,
            4'd10:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

// ===== src/dnd_in_if.sv =====
// Input channel: one day count per transaction.
interface dnd_in_if;
    import dnd_pkg::*;

    logic       valid;
    logic       ready;
    day_count_t day_count;

    modport source (output valid, output day_count, input ready);
    modport sink   (input valid, input day_count, output ready);
endinterface

// ===== src/dnd_out_if.sv =====
// Output channel: one calendar date per transaction.
interface dnd_out_if;
    import dnd_pkg::*;

    logic     valid;
    logic     ready;
    year_t    year;
    month_t   month_number;
    mday_t    day_of_month;
    weekday_t weekday;
    logic     out_of_range;

    modport source (output valid, output year, output month_number, output day_of_month,
                    output weekday, output out_of_range, input ready);
    modport sink   (input valid, input year, input month_number, input day_of_month,
                    input weekday, input out_of_range, output ready);
endinterface

// ===== src/day_number_to_date_top.sv =====
// Timing: from accept to result valid, the weekday reduction sets the time for out-of-range
//   counts and short dates; longer dates are set by one shared subtract/compare unit that
//   strips 400-, 100-, 4- and 1-year blocks, then months.
// Throughput: one transaction at a time; ready returns once the result is in the output
//   register, so the next count may enter while the result waits.
// Reset: rst_n clears the sequencer and the output valid; no clearing pass.
module day_number_to_date_top (
    input  logic         clk,
    input  logic         rst_n,
    dnd_in_if.sink       in_ch,
    dnd_out_if.source    out_ch
);
    import dnd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_Y400 = 3'd1;
    localparam logic [2:0] ST_Y100 = 3'd2;
    localparam logic [2:0] ST_Y4   = 3'd3;
    localparam logic [2:0] ST_Y1   = 3'd4;
    localparam logic [2:0] ST_MON  = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam logic [3:0] WD_DIGITS = 4'd8;

    logic [2:0]  state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        oor_reg, oor_next;
    logic [3:0]  wd_cnt_reg, wd_cnt_next;

    day_count_t  rem_reg, rem_next;
    year_t       yr_reg, yr_next;
    logic [1:0]  cidx_reg, cidx_next;
    logic [4:0]  qidx_reg, qidx_next;
    logic [1:0]  yidx_reg, yidx_next;
    month_t      mon_reg, mon_next;
    logic [23:0] wd_sh_reg, wd_sh_next;
    logic [2:0]  wd_r_reg, wd_r_next;

    year_t       o_year_reg, o_year_next;
    month_t      o_mon_reg, o_mon_next;
    mday_t       o_mday_reg, o_mday_next;
    weekday_t    o_wd_reg, o_wd_next;

    logic        in_acc;
    logic        leap_yr;
    logic        short_quad;
    day_count_t  len;
    logic        ge;
    day_count_t  diff;
    logic [3:0]  wd_sum;
    logic [3:0]  wd_fin;
    logic        finish;

    assign in_acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    // First quad of a century not divisible by 400 has no leap year.
    assign short_quad = (qidx_reg == 5'd0) && (cidx_reg != 2'd0);
    assign leap_yr    = (yidx_reg == 2'd0) && !short_quad;

    // Shared subtract/compare unit
    always_comb
    begin
        case (state_reg)
            ST_Y400: len = LEN_400Y;
            ST_Y100: len = (cidx_reg == 2'd0) ? LEN_100Y_LEAP : LEN_100Y;
            ST_Y4:   len = short_quad ? LEN_4Y : LEN_4Y_LEAP;
            ST_Y1:   len = leap_yr ? LEN_1Y_LEAP : LEN_1Y;
            ST_MON:  len = {17'd0, month_days(mon_reg, leap_yr)};
            default: len = LEN_1Y;
        endcase
    end

    assign ge   = (rem_reg >= len);
    assign diff = rem_reg - len;

    // Weekday: 8 == 1 mod 7, so sum octal digits mod 7, one digit a cycle.
    assign wd_sum = {1'b0, wd_r_reg} + {1'b0, wd_sh_reg[2:0]};
    assign wd_fin = ({1'b0, wd_r_reg} + 4'd6 > 4'd7) ? ({1'b0, wd_r_reg} - 4'd1)
                                                      : ({1'b0, wd_r_reg} + 4'd6);

    assign finish = (state_reg == ST_DONE) && (wd_cnt_reg == WD_DIGITS)
                    && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        oor_next       = oor_reg;
        wd_cnt_next    = wd_cnt_reg;
        rem_next       = rem_reg;
        yr_next        = yr_reg;
        cidx_next      = cidx_reg;
        qidx_next      = qidx_reg;
        yidx_next      = yidx_reg;
        mon_next       = mon_reg;
        wd_sh_next     = wd_sh_reg;
        wd_r_next      = wd_r_reg;
        o_year_next    = o_year_reg;
        o_mon_next     = o_mon_reg;
        o_mday_next    = o_mday_reg;
        o_wd_next      = o_wd_reg;

        if (wd_cnt_reg != WD_DIGITS)
        begin
            wd_r_next   = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
            wd_sh_next  = {3'd0, wd_sh_reg[23:3]};
            wd_cnt_next = wd_cnt_reg + 4'd1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    rem_next    = in_ch.day_count;
                    yr_next     = FIRST_YEAR;
                    cidx_next   = 2'd0;
                    qidx_next   = 5'd0;
                    yidx_next   = 2'd0;
                    mon_next    = 4'd0;
                    wd_sh_next  = {2'd0, in_ch.day_count};
                    wd_r_next   = 3'd0;
                    wd_cnt_next = 4'd0;
                    oor_next    = (in_ch.day_count >= DAYS_TO_END);
                    state_next  = (in_ch.day_count >= DAYS_TO_END) ? ST_DONE : ST_Y400;
                end
            end
            ST_Y400:
            begin
                if (ge)
                begin
                    rem_next = diff;
                    yr_next  = yr_reg + 14'd400;
                end
                else
                begin
                    state_next = ST_Y100;
                end
            end
            ST_Y100:
            begin
                if (ge)
                begin
                    rem_next  = diff;
                    yr_next   = yr_reg + 14'd100;
                    cidx_next = cidx_reg + 2'd1;
                end
                else
                begin
                    state_next = ST_Y4;
                end
            end
            ST_Y4:
            begin
                if (ge)
                begin
                    rem_next  = diff;
                    yr_next   = yr_reg + 14'd4;
                    qidx_next = qidx_reg + 5'd1;
                end
                else
                begin
                    state_next = ST_Y1;
                end
            end
            ST_Y1:
            begin
                if (ge)
                begin
                    rem_next  = diff;
                    yr_next   = yr_reg + 14'd1;
                    yidx_next = yidx_reg + 2'd1;
                end
                else
                begin
                    state_next = ST_MON;
                end
            end
            ST_MON:
            begin
                if ((mon_reg < LAST_MONTH) && ge)
                begin
                    rem_next = diff;
                    mon_next = mon_reg + 4'd1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (finish)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (oor_reg)
                    begin
                        o_year_next = '0;
                        o_mon_next  = '0;
                        o_mday_next = '0;
                        o_wd_next   = '0;
                    end
                    else
                    begin
                        o_year_next = yr_reg;
                        o_mon_next  = mon_reg + 4'd1;
                        o_mday_next = rem_reg[4:0] + 5'd1;
                        o_wd_next   = wd_fin[2:0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            oor_reg       <= 1'b0;
            wd_cnt_reg    <= WD_DIGITS;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            oor_reg       <= oor_next;
            wd_cnt_reg    <= wd_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        yr_reg     <= yr_next;
        cidx_reg   <= cidx_next;
        qidx_reg   <= qidx_next;
        yidx_reg   <= yidx_next;
        mon_reg    <= mon_next;
        wd_sh_reg  <= wd_sh_next;
        wd_r_reg   <= wd_r_next;
        o_year_reg <= o_year_next;
        o_mon_reg  <= o_mon_next;
        o_mday_reg <= o_mday_next;
        o_wd_reg   <= o_wd_next;
    end

    // Flag is registered with the fields on the finishing transaction.
    logic o_oor_reg;
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            o_oor_reg <= oor_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.year         = o_year_reg;
    assign out_ch.month_number = o_mon_reg;
    assign out_ch.day_of_month = o_mday_reg;
    assign out_ch.weekday      = o_wd_reg;
    assign out_ch.out_of_range = o_oor_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ch.ready)
        else $error("input accepted while previous conversion still running");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.out_of_range) |-> (out_ch.year == 14'd0
            && out_ch.month_number == 4'd0 && out_ch.day_of_month == 5'd0
            && out_ch.weekday == 3'd0))
        else $error("out-of-range result has nonzero fields");

    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.out_of_range) |-> (out_ch.year >= FIRST_YEAR
            && out_ch.month_number >= 4'd1 && out_ch.month_number <= 4'd12
            && out_ch.day_of_month >= 5'd1 && out_ch.weekday >= 3'd1
            && out_ch.weekday <= 3'd7))
        else $error("in-range result holds an illegal date");

    a_done_has_weekday: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> (wd_cnt_reg == WD_DIGITS))
        else $error("result loaded before weekday reduction finished");
`endif

endmodule

// ===== bench/dnd_date_checker.sv =====
// Scoreboard for the day-number-to-date converter: predicts each date and compares results.
`timescale 1ns / 1ps

module dnd_date_checker (
    input  logic        clk,
    input  logic        rst_n,
    dnd_in_if           in_ch,
    dnd_out_if          out_ch,
    output int unsigned fail_count,
    output int unsigned pending
);
    import dnd_pkg::*;

    typedef struct packed {
        year_t    year;
        month_t   month_number;
        mday_t    day_of_month;
        weekday_t weekday;
        logic     out_of_range;
    } cal_date_t;

    localparam int unsigned DAYS_PER_400Y = 146097;
    localparam int unsigned LAST_DAY_IDX  = 2921940;   // first count past 9999-12-31
    localparam int unsigned NORMAL_MONTH_DAYS [12] =
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    cal_date_t   dates_due [$];
    int unsigned mismatches = 0;
    int unsigned due_now    = 0;

    assign fail_count = mismatches;
    assign pending    = due_now;

    function automatic bit gregorian_leap(input int unsigned yr);
        return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned mon_idx, input bit leap);
        return NORMAL_MONTH_DAYS[mon_idx] + ((mon_idx == 1 && leap) ? 1 : 0);
    endfunction

    function automatic cal_date_t calendar_of(input day_count_t count);
        cal_date_t   d;
        int unsigned left;
        int unsigned yr;
        int unsigned mon_idx;
        int unsigned wd;
        bit          leap;
        d = '0;
        if (count >= LAST_DAY_IDX)
        begin
            d.out_of_range = 1'b1;
            return d;
        end
        wd = count % 7 + 6;
        if (wd > 7)
            wd -= 7;
        // 2000 starts a 400-year cycle, so whole cycles come off first
        yr   = 2000 + (count / DAYS_PER_400Y) * 400;
        left = count % DAYS_PER_400Y;
        while (left >= (gregorian_leap(yr) ? 366 : 365))
        begin
            left -= gregorian_leap(yr) ? 366 : 365;
            yr++;
        end
        leap    = gregorian_leap(yr);
        mon_idx = 0;
        while (mon_idx < 11 && left >= days_in_month(mon_idx, leap))
        begin
            left -= days_in_month(mon_idx, leap);
            mon_idx++;
        end
        d.year         = year_t'(yr);
        d.month_number = month_t'(mon_idx + 1);
        d.day_of_month = mday_t'(left + 1);
        d.weekday      = weekday_t'(wd);
        return d;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    always @(posedge clk)
    begin
        cal_date_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (dates_due.size() == 0)
                    report_mismatch("unexpected result transaction", 1, 0);
                else
                begin
                    want = dates_due.pop_front();
                    if (out_ch.year != want.year)
                        report_mismatch("year", out_ch.year, want.year);
                    if (out_ch.month_number != want.month_number)
                        report_mismatch("month_number", out_ch.month_number,
                                        want.month_number);
                    if (out_ch.day_of_month != want.day_of_month)
                        report_mismatch("day_of_month", out_ch.day_of_month,
                                        want.day_of_month);
                    if (out_ch.weekday != want.weekday)
                        report_mismatch("weekday", out_ch.weekday, want.weekday);
                    if (out_ch.out_of_range != want.out_of_range)
                        report_mismatch("out_of_range", out_ch.out_of_range,
                                        want.out_of_range);
                end
            end
            if (in_ch.valid && in_ch.ready)
                dates_due.push_back(calendar_of(in_ch.day_count));
            due_now = dates_due.size();
        end
    end

endmodule

// ===== bench/day_number_to_date_top_tb.sv =====
// Top-level bench for the day-number-to-date converter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module day_number_to_date_top_tb;
    import dnd_pkg::*;

    localparam int unsigned RANDOM_COUNTS = 850;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 100;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count  = 0;
    int unsigned counts_sent  = 0;
    int unsigned beyond_sent  = 0;
    bit          idle_on      = 1'b0;
    bit          hold_req     = 1'b0;

    dnd_in_if  in_ch ();
    dnd_out_if out_ch ();

    day_number_to_date_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    dnd_date_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Mostly valid calendar counts, biased toward cycle and century edges.
    function automatic day_count_t pick_count();
        int unsigned sel;
        int unsigned val;
        sel = $urandom_range(99);
        if (sel < 55)
            val = $urandom_range(DAYS_TO_END - 1, 0);
        else if (sel < 67)
            val = $urandom_range(19, 0) * 146097 + $urandom_range(1500, 0);
        else if (sel < 77)
            val = $urandom_range(79, 0) * 36524 + $urandom_range(800, 0);
        else if (sel < 87)
            val = $urandom_range(4194303, DAYS_TO_END);
        else if (sel < 93)
            val = $urandom_range(DAYS_TO_END + 40, DAYS_TO_END - 800);
        else
            val = $urandom_range(3000, 0);
        return day_count_t'(val);
    endfunction

    task automatic send_count(input day_count_t count);
        if (idle_on && $urandom_range(99) < 22)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.day_count <= count;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        counts_sent++;
        if (count >= DAYS_TO_END)
            beyond_sent++;
    endtask

    // Result side: random back-pressure plus one long hold on request.
    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(99) < 22)
                out_ch.ready <= 1'b0;
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        day_count_t corner_counts [$];
        corner_counts = '{
            22'd0, 22'd1, 22'd2, 22'd3, 22'd4, 22'd5, 22'd6,  // one full week from Saturday
            22'd59,                                           // 2000-02-29, leap century
            22'd365, 22'd366, 22'd730,                        // year ends, leap and plain
            22'd36524, 22'd36525, 22'd36583, 22'd36584,       // 2100 is not a leap year
            22'd146096, 22'd146097, 22'd146156,               // 400-year cycle edge
            DAYS_TO_END - 22'd1, DAYS_TO_END, DAYS_TO_END + 22'd1,
            22'h2AAAAA, 22'h155555, 22'h3FFFFF
        };

        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.day_count <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_counts[i])
            send_count(corner_counts[i]);

        for (int unsigned n = 0; n < RANDOM_COUNTS; n++)
        begin
            // quiet stretch in the middle with no gaps on either side
            idle_on = !(n >= 300 && n < 500);
            if (n == 600)
                hold_req = 1'b1;
            send_count(pick_count());
        end
        in_ch.valid <= 1'b0;
        // let the checker log the last transaction before polling its queue
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d day counts, %0d of them past 9999-12-31,", counts_sent,
                 beyond_sent);
        $display("with random gaps on both channels and one %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
